// ===== hw/rtl/ght_pkg.sv =====
// Package: command, status and payload types for the handle table.
package ght_pkg;

   // table size is tied to the 6-bit slot fields and 7-bit live count
   localparam int SLOT_COUNT = 64;

   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_COLLECT = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_READY = 3'd1,
      ST_INVALID   = 3'd2,
      ST_FULL      = 3'd3,
      ST_GEN_EXH   = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_Q_FULL    = 3'd6
   } status_type;

   localparam logic [2:0] RT_INVALID = 3'd0;
   localparam logic [2:0] RT_BUFFER  = 3'd1;
   localparam logic [2:0] RT_TEXTURE = 3'd2;
   localparam logic [2:0] RT_TARGET  = 3'd3;
   localparam logic [2:0] RT_SAMPLER = 3'd4;
   localparam logic [2:0] RT_PIPE    = 3'd5;

   localparam logic [0:0] CSR_READY   = 1'd0;
   localparam logic [0:0] CSR_MAX_DIM = 1'd1;

   localparam logic [15:0] MAX_DIM_RESET = 16'd16384;
   localparam logic [31:0] GEN_MAX       = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  resource_type;
      logic [31:0] buffer_bytes;
      logic [15:0] tex_width;
      logic [15:0] tex_height;
      logic [5:0]  slot_index;
      logic [31:0] handle_generation;
      logic [47:0] retire_fence;
      logic [47:0] completed_fence;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        kind;
      logic [5:0]  out_slot;
      logic [31:0] out_generation;
      logic [2:0]  out_type;
      logic        is_alive;
      logic [5:0]  released_count;
      logic [6:0]  live_count;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_ALLOC,
      S_DESTROY,
      S_COLLECT,
      S_COL_DONE,
      S_REPLY
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic scan_clr;  // reset scan pointer
      logic scan_step; // advance scan pointer
      logic alloc;     // commit create
      logic destroy;   // commit destroy
      logic col_step;  // process one queue entry
      logic col_done;  // commit new fill
      logic reply;     // emit reply
      logic [2:0] status;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type command;
      logic    ready;
      logic    req_valid;
      logic    live;
      logic    q_full;
      logic    scan_hit;
      logic    scan_end;
      logic    pick_exh;
      logic    tbl_full;
      logic    col_end;
   } sts_type;

endpackage

// ===== hw/rtl/generational_handle_table.sv =====
// Top level: generational handle table with fence-keyed retire queue.
//
// Usage:
//  - Request channel: drive req_data and raise start; the request is taken
//    at a clock edge with start high and busy low. busy stays high until
//    the final response of the request is on the ports.
//  - Response channel: each response shows on rsp_data for one cycle with
//    rsp_valid high; the receiver cannot stall. rsp_data.last marks the
//    final response of a request.
//  - CSR port: csr_we/csr_index/csr_wdata, index 0 device_ready,
//    index 1 max_texture_dimension. Write only while idle.
//  - Order: query, not-ready and rejected create reply from decode; destroy
//    from its own state; create after the lowest-free search, which steps
//    past opened slots one per cycle. Collect: one step per queued entry, a
//    retired entry's notice the cycle after its step, a fill commit, then
//    the reply. The next request is taken at the edge ending the reply.
//  - Reset (synchronous, active high) clears the slot table flags, the
//    open count, the queue fill and the CSRs; no clearing pass is needed.
module generational_handle_table #(
   parameter int RETIRE_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ght_pkg::req_type  req_data,
   output logic             rsp_valid,
   output ght_pkg::rsp_type  rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);
   import ght_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic    ctrl_busy;

   // hold busy while the final response is still in flight
   assign busy = ctrl_busy || (rsp_valid && !rsp_data.last) || ctl.reply;

   ght_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (ctrl_busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   ght_datapath #(
      .RETIRE_DEPTH (RETIRE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== hw/rtl/ght_ctrl.sv =====
// Controller: sequences each request through the datapath.
module ght_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ght_pkg::sts_type sts,
   output ght_pkg::ctl_type ctl
);
   import ght_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.scan_clr = 1'b1;
            if (sts.command == CMD_QUERY) begin
               ctl.reply = 1'b1;
               ctl.status = ST_OK;
               state_in = S_IDLE;
            end else if (!sts.ready) begin
               ctl.reply = 1'b1;
               ctl.status = ST_NOT_READY;
               state_in = S_IDLE;
            end else begin
               case (sts.command)
                  CMD_CREATE: begin
                     if (!sts.req_valid) begin
                        ctl.reply = 1'b1;
                        ctl.status = ST_INVALID;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_DESTROY: state_in = S_DESTROY;
                  default: state_in = S_COLLECT;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.scan_hit || sts.scan_end) begin
               state_in = S_ALLOC;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         S_ALLOC: begin
            ctl.reply = 1'b1;
            state_in = S_IDLE;
            if (sts.scan_hit && sts.pick_exh) begin
               ctl.status = ST_GEN_EXH;
            end else if (!sts.scan_hit && sts.tbl_full) begin
               ctl.status = ST_FULL;
            end else begin
               ctl.alloc = 1'b1;
               ctl.status = ST_OK;
            end
         end
         S_DESTROY: begin
            ctl.reply = 1'b1;
            state_in = S_IDLE;
            if (!sts.live) begin
               ctl.status = ST_NOT_FOUND;
            end else if (sts.q_full) begin
               ctl.status = ST_Q_FULL;
            end else begin
               ctl.destroy = 1'b1;
               ctl.status = ST_OK;
            end
         end
         S_COLLECT: begin
            if (sts.col_end) begin
               state_in = S_COL_DONE;
            end else begin
               ctl.col_step = 1'b1;
            end
         end
         S_COL_DONE: begin
            ctl.col_done = 1'b1;
            state_in = S_REPLY;
         end
         S_REPLY: begin
            ctl.reply = 1'b1;
            ctl.status = ST_OK;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/ght_datapath.sv =====
// Datapath: slot table, retire queue and result formatting.
module ght_datapath #(
   parameter int RETIRE_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  ght_pkg::req_type  req_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   input  ght_pkg::ctl_type  ctl,
   output ght_pkg::sts_type  sts,
   output logic             rsp_valid,
   output ght_pkg::rsp_type  rsp_data
);
   import ght_pkg::*;

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int QW = $clog2(RETIRE_DEPTH);

   logic        ready_ff;
   logic [15:0] max_dim_ff;
   req_type     req_ff;

   logic [SLOT_COUNT-1:0] alive_ff, pending_ff;
   logic [31:0]           gen_mem [SLOT_COUNT];
   logic [2:0]            kind_mem [SLOT_COUNT];
   logic [SW:0]           opened_ff;
   logic [6:0]            live_ff;

   // registered reads: handle slot at load, scan slot every cycle
   logic [31:0] hdl_gen_ff, scan_gen_ff;
   logic [2:0]  hdl_kind_ff;

   logic [5:0]  q_slot [RETIRE_DEPTH];
   logic [31:0] q_gen  [RETIRE_DEPTH];
   logic [2:0]  q_kind [RETIRE_DEPTH];
   logic [47:0] q_at   [RETIRE_DEPTH];
   logic [QW:0] fill_ff, rd_ff, wr_ff;
   logic [5:0]  rel_ff;

   logic [SW:0] scan_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [SW-1:0] idx;
   logic [SW-1:0] load_idx;
   logic [SW-1:0] scan_idx;
   logic [QW-1:0] rd_idx;
   logic          idx_in_range, type_ok, dim_ok, live, fence_hit;
   logic [31:0]   pick_gen;

   assign idx      = SW'(req_ff.slot_index);
   assign load_idx = SW'(req_data.slot_index);
   assign scan_idx = scan_ff[SW-1:0];
   assign rd_idx   = rd_ff[QW-1:0];
   assign pick_gen = scan_gen_ff;
   assign idx_in_range = ({{(32-6){1'b0}}, req_ff.slot_index} < 32'(opened_ff));
   assign type_ok = (req_ff.resource_type != RT_INVALID) && (req_ff.resource_type <= RT_PIPE);
   assign dim_ok  = (req_ff.tex_width != 16'd0) && (req_ff.tex_height != 16'd0) &&
                    (req_ff.tex_width <= max_dim_ff) && (req_ff.tex_height <= max_dim_ff);
   assign live = type_ok && idx_in_range && alive_ff[idx] &&
                 (hdl_gen_ff == req_ff.handle_generation) &&
                 (hdl_kind_ff == req_ff.resource_type);
   assign fence_hit = (q_at[rd_idx] <= req_ff.completed_fence);

   always_comb begin
      sts.command   = cmd_type'(req_ff.command);
      sts.ready     = ready_ff;
      case (req_ff.resource_type)
         RT_BUFFER:              sts.req_valid = (req_ff.buffer_bytes != 32'd0);
         RT_TEXTURE, RT_TARGET:  sts.req_valid = dim_ok;
         RT_SAMPLER, RT_PIPE:    sts.req_valid = 1'b1;
         default:                sts.req_valid = 1'b0;
      endcase
      sts.live      = live;
      sts.q_full    = (fill_ff == (QW+1)'(RETIRE_DEPTH));
      sts.scan_end  = (scan_ff >= opened_ff);
      sts.scan_hit  = !sts.scan_end && !alive_ff[scan_idx] && !pending_ff[scan_idx];
      sts.pick_exh  = (pick_gen == GEN_MAX);
      sts.tbl_full  = (opened_ff == (SW+1)'(SLOT_COUNT));
      sts.col_end   = (rd_ff == fill_ff);
   end

   // next response: retire notice on a hit step, command reply on reply
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      if (ctl.col_step) begin
         rsp_in                = '0;
         rsp_in.kind           = 1'b1;
         rsp_in.out_slot       = q_slot[rd_idx];
         rsp_in.out_generation = q_gen[rd_idx];
         rsp_in.out_type       = q_kind[rd_idx];
         rsp_in.live_count     = live_ff;
         rsp_valid_in          = fence_hit;
      end
      if (ctl.reply) begin
         rsp_in                = '0;
         rsp_in.status         = ctl.status;
         rsp_in.last           = 1'b1;
         rsp_in.live_count     = ctl.alloc ? live_ff + 7'd1 :
                                 (ctl.destroy ? live_ff - 7'd1 : live_ff);
         rsp_in.released_count = (sts.command == CMD_COLLECT) ? rel_ff : 6'd0;
         rsp_in.is_alive       = (sts.command == CMD_QUERY) ? live : 1'b0;
         if (ctl.alloc) begin
            rsp_in.out_slot       = 6'(scan_idx);
            rsp_in.out_generation = sts.scan_hit ? pick_gen + 32'd1 : 32'd0;
            rsp_in.out_type       = req_ff.resource_type;
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         max_dim_ff   <= MAX_DIM_RESET;
         alive_ff     <= '0;
         pending_ff   <= '0;
         opened_ff    <= '0;
         live_ff      <= '0;
         fill_ff      <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         rel_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == CSR_READY) begin
               ready_ff <= csr_wdata[0];
            end else begin
               max_dim_ff <= csr_wdata;
            end
         end
         if (ctl.scan_clr) begin
            scan_ff <= '0;
            rd_ff   <= '0;
            wr_ff   <= '0;
            rel_ff  <= '0;
         end
         if (ctl.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (ctl.alloc) begin
            alive_ff[scan_idx]   <= 1'b1;
            pending_ff[scan_idx] <= 1'b0;
            live_ff              <= live_ff + 1'b1;
            if (!sts.scan_hit) begin
               opened_ff <= opened_ff + 1'b1;
            end
         end
         if (ctl.destroy) begin
            alive_ff[idx]   <= 1'b0;
            pending_ff[idx] <= 1'b1;
            fill_ff         <= fill_ff + 1'b1;
            live_ff         <= live_ff - 1'b1;
         end
         if (ctl.col_step) begin
            rd_ff <= rd_ff + 1'b1;
            if (fence_hit) begin
               pending_ff[SW'(q_slot[rd_idx])] <= 1'b0;
               rel_ff <= rel_ff + 1'b1;
            end else begin
               wr_ff <= wr_ff + 1'b1;
            end
         end
         if (ctl.col_done) begin
            fill_ff <= wr_ff;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff      <= req_data;
         hdl_gen_ff  <= gen_mem[load_idx];
         hdl_kind_ff <= kind_mem[load_idx];
      end
      scan_gen_ff <= gen_mem[scan_idx];
      if (ctl.alloc) begin
         gen_mem[scan_idx]  <= sts.scan_hit ? pick_gen + 32'd1 : 32'd0;
         kind_mem[scan_idx] <= req_ff.resource_type;
      end
      if (ctl.destroy) begin
         q_slot[fill_ff[QW-1:0]] <= req_ff.slot_index;
         q_gen[fill_ff[QW-1:0]]  <= req_ff.handle_generation;
         q_kind[fill_ff[QW-1:0]] <= req_ff.resource_type;
         q_at[fill_ff[QW-1:0]]   <= req_ff.retire_fence;
      end
      if (ctl.col_step && !fence_hit) begin
         q_slot[wr_ff[QW-1:0]] <= q_slot[rd_idx];
         q_gen[wr_ff[QW-1:0]]  <= q_gen[rd_idx];
         q_kind[wr_ff[QW-1:0]] <= q_kind[rd_idx];
         q_at[wr_ff[QW-1:0]]   <= q_at[rd_idx];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
